// ===== rtl/arpc_pkg.sv =====
// arp cache package: table size, operation codes, index helpers and the
// command/status structs shared by the controller and the datapath
// no dependencies
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAX_OUT = 8;
    localparam int CNT_W   = $clog2(MAX_OUT);
    localparam int OIDX_W  = 3;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } arpc_cmd_t;

    typedef struct packed {
        logic op_valid;
        logic op_scan;
        logic at_end;
        logic out_free;
        logic pend_cap;
    } arpc_sts_t;

    // low bits of a slot number as carried on the result word
    function automatic logic [OIDX_W-1:0] to_out_idx(input idx_t i);
        logic [IDX_W+OIDX_W-1:0] t;
        t = {{OIDX_W{1'b0}}, i};
        return t[OIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arpc_if.sv =====
// valid/ready channel interfaces for the arp cache request and result words
// uses no package
`default_nettype none

interface arpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic [31:0] now_time;

    modport source (output valid, operation, ip_address, mac_address, now_time,
                    input ready);
    modport sink   (input valid, operation, ip_address, mac_address, now_time,
                    output ready);
endinterface

interface arpc_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [2:0] entry_index;
    logic       last;

    modport source (output valid, found, entry_index, last, input ready);
    modport sink   (input valid, found, entry_index, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/arpc_ctrl.sv =====
// arp cache controller: sequences capture, table sweep and the final result
// depends on arpc_pkg
`default_nettype none

module arpc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire arpc_pkg::arpc_sts_t sts,
    output arpc_pkg::arpc_cmd_t    cmd
);
    import arpc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!sts.op_valid || sts.pend_cap)
                begin
                    state_next = ST_FINISH;
                end
                else if (!sts.op_scan || sts.out_free)
                begin
                    // scan steps may push a word, so they wait for room
                    cmd.step = 1'b1;
                    if (sts.at_end)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/arpc_dpath.sv =====
// arp cache datapath: slot table, sweep trackers, age limit and result register
// depends on arpc_pkg
`default_nettype none

module arpc_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire arpc_pkg::arpc_cmd_t cmd,
    output arpc_pkg::arpc_sts_t      sts,
    input  wire logic [1:0]          operation,
    input  wire logic [31:0]         ip_address,
    input  wire logic [47:0]         mac_address,
    input  wire logic [31:0]         now_time,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     found,
    output logic [2:0]               entry_index,
    output logic                     last
);
    import arpc_pkg::*;

    logic [31:0]      age_limit_reg;
    logic [ENTRIES-1:0] slot_valid_reg;
    logic [31:0]      slot_ip_reg    [ENTRIES];
    logic [47:0]      slot_mac_reg   [ENTRIES];
    logic [31:0]      slot_stamp_reg [ENTRIES];

    logic [1:0]       op_reg;
    logic [31:0]      ip_reg;
    logic [47:0]      mac_reg;
    logic [31:0]      now_reg;

    idx_t             idx_reg;
    logic             hit_v_reg;
    idx_t             hit_idx_reg;
    logic             free_v_reg;
    idx_t             free_idx_reg;
    idx_t             old_idx_reg;
    logic [31:0]      old_stamp_reg;
    logic             pend_v_reg;
    idx_t             pend_idx_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             out_valid_reg;
    logic             found_reg;
    logic [2:0]       index_reg;
    logic             last_reg;

    logic             cur_valid;
    logic [31:0]      cur_ip;
    logic [31:0]      cur_stamp;
    logic [31:0]      limit;
    logic             expired;
    logic             ip_match;
    logic             older;
    logic             is_scan;
    logic             scan_emit;
    idx_t             ins_slot;
    logic             fin_found;
    idx_t             fin_idx;

    assign cur_valid = slot_valid_reg[idx_reg];
    assign cur_ip    = slot_ip_reg[idx_reg];
    assign cur_stamp = slot_stamp_reg[idx_reg];
    // expiry uses the wrapped 32-bit sum
    assign limit     = age_limit_reg + cur_stamp;
    assign is_scan   = (op_reg == OP_SCAN);
    assign expired   = cur_valid && (limit < now_reg);
    assign ip_match  = cur_valid && (cur_ip == ip_reg);
    assign older     = (idx_reg == '0) || (cur_stamp < old_stamp_reg);
    assign scan_emit = cmd.step && is_scan && expired && pend_v_reg;
    assign ins_slot  = free_v_reg ? free_idx_reg : old_idx_reg;

    assign sts.op_valid = (op_reg == OP_INSERT) || (op_reg == OP_LOOKUP) || is_scan;
    assign sts.op_scan  = is_scan;
    assign sts.at_end   = (idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.out_free = !out_valid_reg || out_ready;
    // pending word is the last one the scan may report
    assign sts.pend_cap = pend_v_reg && (cnt_reg == CNT_W'(MAX_OUT - 1));

    always_comb
    begin
        fin_found = 1'b0;
        fin_idx   = '0;
        case (op_reg)
            OP_INSERT:
            begin
                fin_found = hit_v_reg;
                fin_idx   = hit_v_reg ? hit_idx_reg : ins_slot;
            end
            OP_LOOKUP:
            begin
                fin_found = hit_v_reg;
                fin_idx   = hit_v_reg ? hit_idx_reg : '0;
            end
            OP_SCAN:
            begin
                fin_found = pend_v_reg;
                fin_idx   = pend_v_reg ? pend_idx_reg : '0;
            end
            default:
            begin
                fin_found = 1'b0;
                fin_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg  <= '0;
            slot_valid_reg <= '0;
            idx_reg        <= '0;
            hit_v_reg      <= 1'b0;
            free_v_reg     <= 1'b0;
            pend_v_reg     <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                idx_reg    <= '0;
                hit_v_reg  <= 1'b0;
                free_v_reg <= 1'b0;
                pend_v_reg <= 1'b0;
                cnt_reg    <= '0;
            end
            if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ip_match)
                begin
                    hit_v_reg <= 1'b1;
                end
                if (!cur_valid)
                begin
                    free_v_reg <= 1'b1;
                end
                if (is_scan && expired)
                begin
                    pend_v_reg <= 1'b1;
                end
                if (scan_emit)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.finish && (op_reg == OP_INSERT) && !hit_v_reg)
            begin
                slot_valid_reg[ins_slot] <= 1'b1;
            end
            if (cmd.finish || scan_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            ip_reg  <= ip_address;
            mac_reg <= mac_address;
            now_reg <= now_time;
        end
        if (cmd.step)
        begin
            // first match and first free slot are kept
            if (ip_match && !hit_v_reg)
            begin
                hit_idx_reg <= idx_reg;
            end
            if (!cur_valid && !free_v_reg)
            begin
                free_idx_reg <= idx_reg;
            end
            if (older)
            begin
                old_idx_reg   <= idx_reg;
                old_stamp_reg <= cur_stamp;
            end
            if (is_scan && expired)
            begin
                pend_idx_reg <= idx_reg;
            end
        end
        if (cmd.finish && (op_reg == OP_INSERT))
        begin
            if (hit_v_reg)
            begin
                slot_stamp_reg[hit_idx_reg] <= now_reg;
            end
            else
            begin
                slot_ip_reg[ins_slot]    <= ip_reg;
                slot_mac_reg[ins_slot]   <= mac_reg;
                slot_stamp_reg[ins_slot] <= now_reg;
            end
        end
        if (cmd.finish)
        begin
            found_reg <= fin_found;
            index_reg <= to_out_idx(fin_idx);
            last_reg  <= 1'b1;
        end
        else if (scan_emit)
        begin
            found_reg <= 1'b1;
            index_reg <= to_out_idx(pend_idx_reg);
            last_reg  <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign entry_index = index_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== rtl/arp_cache_table_core.sv =====
// arp cache table: eight-slot ip to mac cache with insert, lookup and expiry scan
// Request channel in_ch carries operation, ip_address, mac_address and now_time;
// result channel out_ch carries found, entry_index and last, one word per
// result, last set on the final word of a request. cfg_we/cfg_wdata write the
// age limit; the user must write it only while the block is idle, and the block
// itself does not enforce this. A request is captured, then the controller
// sweeps the table one slot per cycle while no scan step waits for room in the
// result register, then writes the final word; an unused operation code skips
// the sweep. One request is in flight at a time; in_ch.ready is high only
// between requests, even while the last word waits on out_ch.
// A scan reports expired slots as it passes them, one word behind, and pauses
// the sweep while the result register is full. A stalled receiver holds the
// result word steady and eventually halts a scan's sweep.
// Reset clears all valid bits, the age limit and the result valid flag; slot
// contents are not cleared, and only those of valid slots affect results.
// depends on arpc_pkg, arpc_if, arpc_ctrl, arpc_dpath
`default_nettype none

module arp_cache_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    arpc_in_if.sink          in_ch,
    arpc_out_if.source       out_ch,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);
    import arpc_pkg::*;

    arpc_cmd_t cmd;
    arpc_sts_t sts;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (in_ch.operation),
        .ip_address  (in_ch.ip_address),
        .mac_address (in_ch.mac_address),
        .now_time    (in_ch.now_time),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .found       (out_ch.found),
        .entry_index (out_ch.entry_index),
        .last        (out_ch.last)
    );

endmodule

`default_nettype wire

// ===== rtl/arpc_checker.sv =====
// port-level checks for the arp cache table, attached by bind
// depends on arp_cache_table_core and its channel interfaces
`default_nettype none

module arpc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_found,
    input wire logic [2:0] out_index,
    input wire logic       out_last
);

    // a waiting word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found)
            && $stable(out_index) && $stable(out_last))
        else $error("result word changed while stalled");

    // coming out of reset the block is empty and ready
    a_reset_state: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && in_ready)
        else $error("bad state after reset");

    // only scan hits are followed by further words
    a_not_last_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_found)
        else $error("non-final word without a hit");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind arp_cache_table_core arpc_checker u_arpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_found (out_ch.found),
    .out_index (out_ch.entry_index),
    .out_last  (out_ch.last)
);

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for arp_cache_table_core: directed and random insert,
// lookup, expiry scan and unused-code requests, each result word checked against a
// cycle-free table predictor; depends on arpc_pkg, arpc_if and the core rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = ENTRIES + 4;

    typedef struct packed {
        logic       found;
        logic [2:0] entry_index;
        logic       last;
    } arp_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    arpc_in_if  req_ch ();
    arpc_out_if res_ch ();

    arp_cache_table_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (req_ch),
        .out_ch   (res_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // predicted table contents and age limit
    logic        tbl_live  [ENTRIES];
    logic [31:0] tbl_ip    [ENTRIES];
    logic [47:0] tbl_mac   [ENTRIES];
    logic [31:0] tbl_stamp [ENTRIES];
    logic [31:0] max_age;

    arp_result_t owed_results [$];

    int unsigned err_count;
    int unsigned words_checked;
    int unsigned expired_words;
    int unsigned op_count [4];

    logic        send_gaps;
    logic        recv_stalls;
    logic [31:0] sim_now;
    logic [31:0] ip_pool [12];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // works out the result words of one accepted request and updates the table
    function automatic void predict_cache_op(input logic [1:0] op, input logic [31:0] ip,
                                             input logic [47:0] mac, input logic [31:0] now);
        int          hit;
        int          slot;
        int          n;
        int          i;
        logic [31:0] due;
        logic [2:0]  expired [8];
        arp_result_t r;

        hit = -1;
        n   = 0;
        for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && tbl_live[i] && tbl_ip[i] == ip)
                hit = i;
        op_count[op]++;
        r = '{found: 1'b0, entry_index: 3'd0, last: 1'b1};

        case (op)
            OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    tbl_stamp[hit] = now;
                    r.found        = 1'b1;
                    r.entry_index  = hit[2:0];
                end
                else
                begin
                    slot = -1;
                    for (i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !tbl_live[i])
                            slot = i;
                    // table full: oldest stamp goes, lowest slot on ties
                    if (slot < 0)
                    begin
                        slot = 0;
                        for (i = 1; i < ENTRIES; i++)
                            if (tbl_stamp[i] < tbl_stamp[slot])
                                slot = i;
                    end
                    tbl_live[slot]  = 1'b1;
                    tbl_ip[slot]    = ip;
                    tbl_mac[slot]   = mac;
                    tbl_stamp[slot] = now;
                    r.entry_index   = slot[2:0];
                end
                owed_results.push_back(r);
            end
            OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.found       = 1'b1;
                    r.entry_index = hit[2:0];
                end
                owed_results.push_back(r);
            end
            OP_SCAN:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    due = max_age + tbl_stamp[i];
                    if (n < MAX_OUT && tbl_live[i] && due < now)
                    begin
                        expired[n] = i[2:0];
                        n++;
                    end
                end
                if (n == 0)
                    owed_results.push_back(r);
                for (i = 0; i < n; i++)
                begin
                    r.found       = 1'b1;
                    r.entry_index = expired[i];
                    r.last        = (i == n - 1);
                    owed_results.push_back(r);
                end
                expired_words += n;
            end
            default:
                owed_results.push_back(r);
        endcase
    endfunction

    // one request word: optional gap, then hold until the core takes it
    task automatic issue_request(input logic [1:0] op, input logic [31:0] ip,
                                 input logic [47:0] mac, input logic [31:0] now);
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 2) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.ip_address  <= ip;
        req_ch.mac_address <= mac;
        req_ch.now_time    <= now;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_cache_op(op, ip, mac, now);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_age_limit(input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        max_age = value;
    endtask

    // lookup and scan on an empty table, plus the unused operation code
    task automatic test_empty_table();
        issue_request(OP_LOOKUP, 32'h0, 48'h0, 32'h0);
        issue_request(OP_SCAN, 32'h0, 48'h0, 32'hFFFF_FFFF);
        issue_request(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // fill every slot, refresh one, then evict the oldest and the first of a tie
    task automatic test_fill_and_evict();
        logic [63:0] r64;
        int          k;

        issue_request(OP_INSERT, 32'h0, 48'h0, 32'd5);
        issue_request(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd5);
        for (k = 2; k < ENTRIES; k++)
        begin
            r64 = {$urandom, $urandom};
            issue_request(OP_INSERT, 32'h0A00_0000 + k, r64[47:0], 32'd7);
        end
        issue_request(OP_INSERT, 32'hFFFF_FFFF, 48'h0, 32'd9);
        issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'd9);
        issue_request(OP_INSERT, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 32'd10);
        issue_request(OP_INSERT, 32'h5A5A_5A5A, 48'hA5A5_A5A5_A5A5, 32'd11);
        issue_request(OP_LOOKUP, 32'h0, 48'h0, 32'd11);
    endtask

    // scans at both ends of the age limit, including a wrapping sum
    task automatic test_expiry_scan();
        issue_request(OP_SCAN, 32'h0, 48'h0, 32'h0);
        issue_request(OP_SCAN, 32'h0, 48'h0, 32'd8);
        wait_drained();
        write_age_limit(32'hFFFF_FFFF);
        issue_request(OP_SCAN, 32'h0, 48'h0, 32'hFFFF_FFFF);
        wait_drained();
        write_age_limit(32'hFFFF_FFF0);
        issue_request(OP_INSERT, 32'h1234_5678, 48'h0000_0000_0001, 32'h20);
        issue_request(OP_SCAN, 32'h0, 48'h0, 32'h11);
        wait_drained();
    endtask

    // mostly well-formed traffic on a small set of addresses with a moving clock
    task automatic test_random_traffic(input int count, input logic [31:0] age,
                                       input logic gaps, input logic stalls);
        logic [63:0] r64;
        logic [1:0]  op;
        logic [31:0] ip;
        int          k;
        int          pick;

        write_age_limit(age);
        send_gaps   = gaps;
        recv_stalls = stalls;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_INSERT;
            else if (pick < 72)
                op = OP_LOOKUP;
            else if (pick < 95)
                op = OP_SCAN;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 4) == 0)
                ip = $urandom;
            else
                ip = ip_pool[$urandom_range(0, 11)];
            if ($urandom_range(0, 29) == 0)
                sim_now = $urandom;
            else
                sim_now = sim_now + $urandom_range(0, 40);
            r64 = {$urandom, $urandom};
            issue_request(op, ip, r64[47:0], sim_now);
        end
        wait_drained();
    endtask

    // result side: random stall bursts while enabled
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_stalls && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        arp_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            words_checked++;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result word: found=%0b entry_index=%0d last=%0b",
                       res_ch.found, res_ch.entry_index, res_ch.last);
                err_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (res_ch.found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, res_ch.found);
                    err_count++;
                end
                if (res_ch.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, res_ch.entry_index);
                    err_count++;
                end
                if (res_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, res_ch.last);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("arp_cache_table_core regression: fail");
        $finish;
    end

    initial
    begin
        int k;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 32'h0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_INSERT;
        req_ch.ip_address  = 32'h0;
        req_ch.mac_address = 48'h0;
        req_ch.now_time    = 32'h0;
        err_count          = 0;
        words_checked      = 0;
        expired_words      = 0;
        max_age            = 32'h0;
        send_gaps          = 1'b1;
        recv_stalls        = 1'b1;
        sim_now            = $urandom_range(0, 1000);
        for (k = 0; k < 4; k++)
            op_count[k] = 0;
        for (k = 0; k < ENTRIES; k++)
        begin
            tbl_live[k]  = 1'b0;
            tbl_ip[k]    = 32'h0;
            tbl_mac[k]   = 48'h0;
            tbl_stamp[k] = 32'h0;
        end
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (k = 2; k < 12; k++)
            ip_pool[k] = $urandom;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_evict();
        test_expiry_scan();
        test_random_traffic(100, 32'h0, 1'b1, 1'b1);
        test_random_traffic(100, $urandom_range(20, 300), 1'b1, 1'b0);
        test_random_traffic(100, 32'hFFFF_FFFF, 1'b0, 1'b1);
        test_random_traffic(100, $urandom, 1'b1, 1'b1);
        test_random_traffic(100, $urandom_range(0, 60), 1'b0, 1'b0);

        $display("requests: %0d insert, %0d lookup, %0d scan, %0d unused code",
                 op_count[OP_INSERT], op_count[OP_LOOKUP], op_count[OP_SCAN],
                 op_count[OP_UNUSED]);
        $display("%0d result words compared, %0d of them expired-slot reports",
                 words_checked, expired_words);
        if (err_count == 0 && owed_results.size() == 0)
            $display("arp_cache_table_core regression: pass");
        else
            $display("arp_cache_table_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/arpc_pkg.sv
rtl/arpc_if.sv
rtl/arpc_ctrl.sv
rtl/arpc_dpath.sv
rtl/arp_cache_table_core.sv
rtl/arpc_checker.sv
verif/tb.sv
